// ===== hdl/esd_pkg.sv =====
// Shared types and codes for the escape string decoder.
`default_nettype none
package esd_pkg;

	// decode modes
	localparam logic [2:0] MODE_GROUND = 3'd0;
	localparam logic [2:0] MODE_BSLASH = 3'd1;
	localparam logic [2:0] MODE_OCTAL  = 3'd2;
	localparam logic [2:0] MODE_HEX    = 3'd3;
	localparam logic [2:0] MODE_CARET  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_END_OK  = 2'd1;
	localparam logic [1:0] KIND_END_ERR = 2'd2;

	localparam int unsigned COUNT_W = 10;

	typedef struct packed {
		logic [2:0]         mode;
		logic [7:0]         esc;
		logic [COUNT_W-1:0] cnt;
	} esd_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [1:0]         kind;
		logic [7:0]         value;
		logic               last;
	} esd_item_t;

endpackage
`default_nettype wire

// ===== hdl/esd_decode.sv =====
// Per-byte decode step: next state and up to two result items.
`default_nettype none
module esd_decode (
	input  esd_pkg::esd_state_t st,
	input  logic [7:0]          in_byte,
	input  logic                equals_ends,
	input  logic [9:0]          count_limit,
	output esd_pkg::esd_state_t st_next,
	output logic [1:0]          res_n,
	output esd_pkg::esd_item_t  res0,
	output esd_pkg::esd_item_t  res1
);
	import esd_pkg::*;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_DEL   = 8'd127;

	function automatic logic [7:0] named_char(input logic [7:0] b);
		logic [7:0] v;
		unique case (b)
			8'h61: v = 8'd7;   // a
			8'h62: v = 8'd8;   // b
			8'h65: v = 8'd27;  // e
			8'h66: v = 8'd12;  // f
			8'h6e: v = 8'd10;  // n
			8'h72: v = 8'd13;  // r
			8'h74: v = 8'd9;   // t
			8'h76: v = 8'd11;  // v
			8'h3f: v = 8'd127; // ?
			8'h5f: v = 8'd32;  // _
			default: v = b;
		endcase
		return v;
	endfunction

	// bit 4 flags a valid hex digit, low bits hold its value
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66)
			r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46)
			r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	function automatic esd_item_t mk_item(input logic [7:0] value, input logic [1:0] kind,
			input logic [9:0] count);
		esd_item_t it;
		it.value = value;
		it.kind  = kind;
		it.count = count;
		it.last  = 1'b0;
		return it;
	endfunction

	function automatic logic [9:0] sat_inc(input logic [9:0] c, input logic [9:0] lim);
		return (c < lim) ? c + 10'd1 : c;
	endfunction

	logic       is_oct;
	logic [4:0] hd;
	logic       gnd;
	logic [1:0] n;
	esd_item_t  res_w [2];
	esd_state_t st_w;

	assign is_oct = (in_byte >= 8'h30) && (in_byte <= 8'h37);
	assign hd     = hex_digit(in_byte);

	always_comb begin
		st_w     = st;
		n        = 2'd0;
		gnd      = 1'b0;
		res_w[0] = '0;
		res_w[1] = '0;
		unique case (st.mode)
			MODE_BSLASH: begin
				st_w.mode = MODE_GROUND;
				if (is_oct) begin
					st_w.esc  = {5'd0, in_byte[2:0]};
					st_w.mode = MODE_OCTAL;
				end else if (in_byte == CH_LX || in_byte == CH_UX) begin
					st_w.esc  = 8'd0;
					st_w.mode = MODE_HEX;
				end else if (in_byte == CH_NUL) begin
					res_w[0] = mk_item(8'd0, KIND_END_ERR, st.cnt);
					n        = 2'd1;
					st_w.cnt = '0;
					st_w.esc = 8'd0;
				end else begin
					res_w[0] = mk_item(named_char(in_byte), KIND_BYTE, 10'd0);
					n        = 2'd1;
					st_w.cnt = sat_inc(st.cnt, count_limit);
				end
			end
			MODE_OCTAL: begin
				if (is_oct) begin
					st_w.esc = {st.esc[4:0], in_byte[2:0]};
				end else begin
					// flush the run, then treat the byte afresh
					res_w[0]  = mk_item(st.esc, KIND_BYTE, 10'd0);
					n         = 2'd1;
					st_w.cnt  = sat_inc(st.cnt, count_limit);
					st_w.mode = MODE_GROUND;
					gnd       = 1'b1;
				end
			end
			MODE_HEX: begin
				if (hd[4]) begin
					st_w.esc = {st.esc[3:0], hd[3:0]};
				end else begin
					res_w[0]  = mk_item(st.esc, KIND_BYTE, 10'd0);
					n         = 2'd1;
					st_w.cnt  = sat_inc(st.cnt, count_limit);
					st_w.mode = MODE_GROUND;
					gnd       = 1'b1;
				end
			end
			MODE_CARET: begin
				st_w.mode = MODE_GROUND;
				if (in_byte >= CH_AT && in_byte <= CH_TILDE) begin
					res_w[0] = mk_item({3'd0, in_byte[4:0]}, KIND_BYTE, 10'd0);
					n        = 2'd1;
					st_w.cnt = sat_inc(st.cnt, count_limit);
				end else if (in_byte == CH_QMARK) begin
					res_w[0] = mk_item(CH_DEL, KIND_BYTE, 10'd0);
					n        = 2'd1;
					st_w.cnt = sat_inc(st.cnt, count_limit);
				end else begin
					res_w[0] = mk_item(8'd0, KIND_END_ERR, st.cnt);
					n        = 2'd1;
					st_w.cnt = '0;
					st_w.esc = 8'd0;
				end
			end
			default: begin
				st_w.mode = MODE_GROUND;
				gnd       = 1'b1;
			end
		endcase

		if (gnd) begin
			priority if (in_byte == CH_COLON || in_byte == CH_NUL ||
					(in_byte == CH_EQ && equals_ends)) begin
				res_w[n[0]] = mk_item(8'd0, KIND_END_OK, st_w.cnt);
				n           = n + 2'd1;
				st_w.cnt    = '0;
				st_w.esc    = 8'd0;
				st_w.mode   = MODE_GROUND;
			end else if (in_byte == CH_BSL) begin
				st_w.mode = MODE_BSLASH;
			end else if (in_byte == CH_CARET) begin
				st_w.mode = MODE_CARET;
			end else begin
				res_w[n[0]] = mk_item(in_byte, KIND_BYTE, 10'd0);
				n           = n + 2'd1;
				st_w.cnt    = sat_inc(st_w.cnt, count_limit);
			end
		end

		res_w[0].last = (n == 2'd1);
		res_w[1].last = (n == 2'd2);
	end

	assign st_next = st_w;
	assign res_n   = n;
	assign res0    = res_w[0];
	assign res1    = res_w[1];

endmodule
`default_nettype wire

// ===== hdl/esd_outq.sv =====
// Four-entry result queue taking up to two items per cycle.
`default_nettype none
module esd_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  esd_pkg::esd_item_t push_a,
	input  esd_pkg::esd_item_t push_b,
	output logic [2:0]         free,
	output esd_pkg::esd_item_t head,
	output logic               head_valid,
	input  logic               head_ready
);
	import esd_pkg::*;

	localparam int unsigned Depth = 4;
	localparam int unsigned AddrW = 2;
	localparam int unsigned CntW  = 3;

	esd_item_t        mem_q [Depth];
	logic [AddrW-1:0] wr_q;
	logic [AddrW-1:0] rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             pop;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign pop        = head_valid && head_ready;
	assign free       = CntW'(Depth) - cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_q] <= push_a;
		if (push_n == 2'd2)
			mem_q[AddrW'(wr_q + 1'b1)] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= AddrW'(wr_q + AddrW'(push_n));
			rd_q  <= AddrW'(rd_q + AddrW'(pop));
			cnt_q <= cnt_q + CntW'(push_n) - CntW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		CntW'(push_n) <= free)
		else $error("result queue overflow");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("result queue count out of range");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + CntW'($past(push_n)) - CntW'($past(pop)))
		else $error("result queue count drift");
`endif

endmodule
`default_nettype wire

// ===== hdl/escape_string_decoder.sv =====
// Top level of the escape string decoder.
// Takes one raw character per beat and returns decoded bytes and end-of-string
// items. A character is registered, decoded combinationally against the mode,
// run accumulator and count registers, and its results, up to two, go into a
// four-entry result queue. One character is accepted per cycle while the queue
// has room for its results; a character that both closes an octal or hex run
// and is itself decoded yields two results, so a steady stream of those is
// held back by the single output port. The byte count saturates at the smaller
// of MAX_COUNT and 1023.
`default_nettype none
module escape_string_decoder #(
	parameter int MAX_COUNT = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic [0:0]  s_tuser,  // [0] equals_ends
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] out_value, [17:8] decoded_count
	output logic [1:0]  m_tuser,  // [1:0] item_kind
	output logic        m_tlast   // last_of_run
);
	import esd_pkg::*;

	localparam logic [9:0] CountLimit = (MAX_COUNT < 1023) ? 10'(MAX_COUNT) : 10'd1023;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eq_s1;
	esd_state_t state_q;
	esd_state_t state_next;
	logic [1:0] res_n;
	esd_item_t  res0;
	esd_item_t  res1;
	logic [2:0] free;
	logic       fire;
	esd_item_t  head;

	esd_decode u_decode (
		.st          (state_q),
		.in_byte     (byte_s1),
		.equals_ends (eq_s1),
		.count_limit (CountLimit),
		.st_next     (state_next),
		.res_n       (res_n),
		.res0        (res0),
		.res1        (res1)
	);

	// advance only when the queue can hold every result of this byte
	assign fire     = valid_s1 && ({1'b0, res_n} <= free);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eq_s1   <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= MODE_GROUND;
			state_q.esc  <= 8'd0;
			state_q.cnt  <= '0;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	esd_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (fire ? res_n : 2'd0),
		.push_a     (res0),
		.push_b     (res1),
		.free       (free),
		.head       (head),
		.head_valid (m_tvalid),
		.head_ready (m_tready)
	);

	assign m_tdata = {6'd0, head.count, head.value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_n != 2'd0 &&
		(res0.kind != KIND_BYTE || (res_n == 2'd2 && res1.kind != KIND_BYTE))
		|=> state_q.mode == MODE_GROUND && state_q.cnt == '0 && state_q.esc == 8'd0)
		else $error("end item did not reset the decoder");
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cnt <= CountLimit)
		else $error("byte count above limit");
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> res_n != 2'd3 && (res_n != 2'd2 || res1.last))
		else $error("bad result count from decode");
`endif

endmodule
`default_nettype wire
